### rtl/cesc_pkg.sv
// Shared types and constants for the connected edge subset counter.
package cesc_pkg;

    localparam int MAX_EDGES    = 32;
    localparam int MAX_VERTICES = 16;
    localparam int VID_W        = 4;
    localparam int CNT_W        = 6;   // holds 0..MAX_EDGES
    localparam int MASK_W       = MAX_EDGES + 1;
    localparam int TALLY_W      = 30;
    localparam int VC_W         = 5;
    localparam int EX_W         = 7;

    // configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_EXTRA_EDGES  = 1'b1;

    typedef enum logic [1:0] {
        JOB_RUN,
        JOB_ZERO,
        JOB_ERR
    } t_job_mode;

    typedef struct packed {
        t_job_mode          mode;
        logic [CNT_W-1:0]   edge_total;
        logic [CNT_W-1:0]   subset_size;
        logic [VC_W-1:0]    nv;
        logic               overflow;
    } t_job;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_CHECK,
        WS_DONE
    } t_walk_state;

    typedef logic [MAX_EDGES-1:0][VID_W-1:0] t_edge_arr;

endpackage

### rtl/cesc_front.sv
// Front end: takes edges into the store and turns a last edge into a job.
module cesc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [cesc_pkg::VID_W-1:0] i_edge_first_vertex,
    input  logic [cesc_pkg::VID_W-1:0] i_edge_second_vertex,
    input  logic                   i_edge_is_last,
    input  logic [cesc_pkg::VC_W-1:0]  i_vertex_count,
    input  logic [cesc_pkg::EX_W-1:0]  i_extra_edges,
    input  logic                   i_release,
    input  logic                   i_q_full,
    output logic                   o_job_push,
    output cesc_pkg::t_job         o_job,
    output cesc_pkg::t_edge_arr    o_store_a,
    output cesc_pkg::t_edge_arr    o_store_b
);
    import cesc_pkg::*;

    t_edge_arr        r_store_a, r_store_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_hold;
    logic             accept;
    logic             keep;
    logic             room;
    logic [CNT_W-1:0] n_cnt;
    logic             n_ovf;
    logic [VC_W-1:0]  nv;
    logic signed [7:0] k_s;

    assign o_full  = r_hold || i_q_full;
    assign accept  = i_push && !o_full;
    assign keep    = i_edge_first_vertex != i_edge_second_vertex;
    assign room    = r_cnt < CNT_W'(MAX_EDGES);
    assign n_cnt   = (keep && room) ? r_cnt + 1'b1 : r_cnt;
    assign n_ovf   = r_ovf || (keep && !room);

    always_comb begin
        if (i_vertex_count == '0) begin
            nv = VC_W'(1);
        end else if (i_vertex_count > VC_W'(MAX_VERTICES)) begin
            nv = VC_W'(MAX_VERTICES);
        end else begin
            nv = i_vertex_count;
        end
        k_s = $signed({3'b000, nv}) - 8'sd1 + $signed({i_extra_edges[EX_W-1], i_extra_edges});
        o_job.edge_total  = n_cnt;
        o_job.subset_size = k_s[CNT_W-1:0];
        o_job.nv          = nv;
        o_job.overflow    = n_ovf;
        if (k_s > $signed({2'b00, n_cnt})) begin
            o_job.mode = JOB_ERR;
        end else if (k_s < 8'sd0) begin
            o_job.mode = JOB_ZERO;
        end else begin
            o_job.mode = JOB_RUN;
        end
    end

    assign o_job_push = accept && i_edge_is_last;
    assign o_store_a  = r_store_a;
    assign o_store_b  = r_store_b;

    always_ff @(posedge i_clk) begin
        if (accept && keep && room) begin
            r_store_a[r_cnt[CNT_W-2:0]] <= i_edge_first_vertex;
            r_store_b[r_cnt[CNT_W-2:0]] <= i_edge_second_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (accept) begin
                if (i_edge_is_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_cnt <= n_cnt;
                    r_ovf <= n_ovf;
                end
            end
            // the store stays frozen until the back end has finished with it
            if (o_job_push) begin
                r_hold <= 1'b1;
            end else if (i_release) begin
                r_hold <= 1'b0;
            end
        end
    end

endmodule

### rtl/cesc_jobq.sv
// Two-entry job queue between front and back end.
module cesc_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cesc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cesc_pkg::t_job o_job
);
    import cesc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/cesc_walk.sv
// Back end: walks all subsets of the chosen size and counts connected ones.
module cesc_walk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  cesc_pkg::t_job              i_job,
    output logic                        o_q_pop,
    input  cesc_pkg::t_edge_arr         i_store_a,
    input  cesc_pkg::t_edge_arr         i_store_b,
    output logic                        o_release,
    output logic                        o_busy,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [cesc_pkg::TALLY_W-1:0] o_connected_subsets,
    output logic                        o_size_error,
    output logic                        o_edge_overflow
);
    import cesc_pkg::*;

    t_walk_state         r_state, n_state;
    t_job                r_job;
    logic [MASK_W-1:0]   r_mask;
    logic [MAX_VERTICES-1:0] r_reach;
    logic [TALLY_W-1:0]  r_tally;
    logic                r_out_valid;
    logic [TALLY_W-1:0]  r_out_tally;
    logic                r_out_err, r_out_ovf;

    logic [MAX_VERTICES-1:0] n_reach, full_set;
    logic [MASK_W-1:0]   low_bit, ripple, next_mask;
    logic [5:0]          tz;
    logic                last_subset, connected, out_take;

    assign out_take = i_pop && r_out_valid;
    assign full_set = MAX_VERTICES'((17'd1 << r_job.nv) - 17'd1);

    // one step of reachability from vertex 0 over the chosen edges
    always_comb begin
        n_reach = r_reach;
        for (int i = 0; i < MAX_EDGES; i++) begin
            if (r_mask[i] && {1'b0, i_store_a[i]} < r_job.nv
                    && {1'b0, i_store_b[i]} < r_job.nv) begin
                if (r_reach[i_store_a[i]]) n_reach[i_store_b[i]] = 1'b1;
                if (r_reach[i_store_b[i]]) n_reach[i_store_a[i]] = 1'b1;
            end
        end
    end

    // next subset of equal popcount
    always_comb begin
        low_bit = r_mask & (~r_mask + 1'b1);
        ripple  = r_mask + low_bit;
        tz      = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) tz = 6'(i);
        end
        next_mask   = ripple | (((ripple ^ r_mask) >> 2) >> tz);
        last_subset = (r_job.subset_size == '0) || ((next_mask >> r_job.edge_total) != '0);
        connected   = (r_reach & full_set) == full_set;
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        o_release = 1'b0;
        case (r_state)
            WS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = (i_job.mode == JOB_RUN) ? WS_CHECK : WS_DONE;
                end
            end
            WS_CHECK: begin
                if (n_reach == r_reach && last_subset) n_state = WS_DONE;
            end
            WS_DONE: begin
                if (!r_out_valid || out_take) begin
                    o_release = 1'b1;
                    n_state   = WS_IDLE;
                end
            end
            default: n_state = WS_IDLE;
        endcase
    end

    assign o_busy = r_state != WS_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == WS_IDLE && o_q_pop) begin
            r_job   <= i_job;
            r_mask  <= MASK_W'((34'd1 << i_job.subset_size) - 34'd1);
            r_reach <= MAX_VERTICES'(1);
            r_tally <= '0;
        end else if (r_state == WS_CHECK) begin
            if (n_reach != r_reach) begin
                r_reach <= n_reach;
            end else begin
                if (connected) r_tally <= r_tally + 1'b1;
                r_mask  <= next_mask;
                r_reach <= MAX_VERTICES'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == WS_DONE && o_release) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == WS_DONE && o_release) begin
            r_out_tally <= (r_job.mode == JOB_RUN) ? r_tally : '0;
            r_out_err   <= r_job.mode == JOB_ERR;
            r_out_ovf   <= r_job.overflow;
        end
    end

    assign o_empty             = !r_out_valid;
    assign o_connected_subsets = r_out_tally;
    assign o_size_error        = r_out_err;
    assign o_edge_overflow     = r_out_ovf;

endmodule

### rtl/connected_edge_subset_counter.sv
// Top level: config registers, edge front end, job queue and subset walker.
// Edges are taken one per cycle while full is low; a last edge holds input off
// (full) until the walk over all K-edge subsets ends and its result is
// registered, with one reachability step per cycle.
// Synchronous active-low reset clears the edge count, flags, queue and walker state
// and config registers (vertex_count 1, extra_edges 0); edge storage is not cleared.
module connected_edge_subset_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [cesc_pkg::VID_W-1:0]   i_edge_first_vertex,
    input  logic [cesc_pkg::VID_W-1:0]   i_edge_second_vertex,
    input  logic                         i_edge_is_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [cesc_pkg::TALLY_W-1:0] o_connected_subsets,
    output logic                         o_size_error,
    output logic                         o_edge_overflow,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [cesc_pkg::EX_W-1:0]    i_cfg_data
);
    import cesc_pkg::*;

    logic [VC_W-1:0] r_vertex_count;
    logic [EX_W-1:0] r_extra_edges;
    logic            job_push, q_full, q_empty, q_pop, release_st, walk_busy;
    t_job            job_in, job_out;
    t_edge_arr       store_a, store_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VC_W'(1);
            r_extra_edges  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_VERTEX_COUNT) r_vertex_count <= i_cfg_data[VC_W-1:0];
            else                                 r_extra_edges  <= i_cfg_data;
        end
    end

    cesc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (push),
        .o_full               (full),
        .i_edge_first_vertex  (i_edge_first_vertex),
        .i_edge_second_vertex (i_edge_second_vertex),
        .i_edge_is_last       (i_edge_is_last),
        .i_vertex_count       (r_vertex_count),
        .i_extra_edges        (r_extra_edges),
        .i_release            (release_st),
        .i_q_full             (q_full),
        .o_job_push           (job_push),
        .o_job                (job_in),
        .o_store_a            (store_a),
        .o_store_b            (store_b)
    );

    cesc_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    cesc_walk u_walk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_job               (job_out),
        .o_q_pop             (q_pop),
        .i_store_a           (store_a),
        .i_store_b           (store_b),
        .o_release           (release_st),
        .o_busy              (walk_busy),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_connected_subsets (o_connected_subsets),
        .o_size_error        (o_size_error),
        .o_edge_overflow     (o_edge_overflow)
    );

    // input must be held off while the walker is using the edge store
    a_full_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_busy |-> full)
        else $error("edge accepted while walk in progress");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_size_error) |-> (o_connected_subsets == '0))
        else $error("size error with nonzero count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule
